### rtl/core/bmt_pkg.sv
// ----------------------------------------------------------------------------
// bmt_pkg
// Shared types, widths and constants of the button, mode and light controller.
// ----------------------------------------------------------------------------
package bmt_pkg;

  // Timer and converter widths
  localparam int TIMER_BITS  = 16;
  localparam int SAMPLE_BITS = 12;

  // Field widths fixed by the register map and the channels
  localparam int LEVEL_W   = 12;
  localparam int TICKS_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int LUMA_W    = 8;
  localparam int MODE_W    = 2;
  localparam int STEP_W    = 3;
  localparam int COUNT_W   = 8;

  // Common compare widths
  localparam int TCMP_W = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;
  localparam int BCMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

  // Low battery blink period
  localparam int BLINK_PERIOD = 500;
  localparam int BLINK_W      = $clog2(BLINK_PERIOD);

  typedef logic [TIMER_BITS-1:0]  timer_t;
  typedef logic [SAMPLE_BITS-1:0] reading_t;
  typedef logic [BLINK_W-1:0]     blink_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [STEP_W-1:0]      step_t;

  localparam timer_t TIMER_MAX = '1;
  localparam blink_t BLINK_LAST = blink_t'(BLINK_PERIOD - 1);

  // Register indexes
  localparam cfg_idx_t REG_LOW_LEVEL   = 3'd0;
  localparam cfg_idx_t REG_FULL_LEVEL  = 3'd1;
  localparam cfg_idx_t REG_UV_TIMEOUT  = 3'd2;
  localparam cfg_idx_t REG_CLICK_GUARD = 3'd3;
  localparam cfg_idx_t REG_MODE_WINDOW = 3'd4;
  localparam cfg_idx_t REG_SLEEP_CHECK = 3'd5;
  localparam cfg_idx_t REG_REFRESH     = 3'd6;
  localparam cfg_idx_t REG_SAMPLE      = 3'd7;

  // Register reset values
  localparam logic [LEVEL_W-1:0] RST_LOW_LEVEL   = 12'd3367;
  localparam logic [LEVEL_W-1:0] RST_FULL_LEVEL  = 12'd3895;
  localparam logic [TICKS_W-1:0] RST_UV_TIMEOUT  = 16'd8000;
  localparam logic [TICKS_W-1:0] RST_CLICK_GUARD = 16'd800;
  localparam logic [TICKS_W-1:0] RST_MODE_WINDOW = 16'd1000;
  localparam logic [TICKS_W-1:0] RST_SLEEP_CHECK = 16'd5000;
  localparam logic [TICKS_W-1:0] RST_REFRESH     = 16'd300;
  localparam logic [TICKS_W-1:0] RST_SAMPLE      = 16'd100;

  // Mode steps
  localparam step_t STEP_OFF  = 3'd0;
  localparam step_t STEP_UV   = 3'd1;
  localparam step_t STEP_MOOD = 3'd2;
  localparam step_t STEP_STOP = 3'd3;

  // Reported modes
  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UV   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOOD = 2'd2;

  typedef struct packed {
    logic [LUMA_W-1:0] red;
    logic [LUMA_W-1:0] green;
    logic [LUMA_W-1:0] blue;
    logic [LUMA_W-1:0] white;
  } colour_t;

  localparam colour_t MOOD_RESET = '{red: 8'd0, green: 8'd50, blue: 8'd200, white: 8'd10};
  localparam colour_t UV_COLOUR  = '{red: 8'd0, green: 8'd0, blue: 8'd255, white: 8'd1};
  localparam colour_t DARK       = '{red: 8'd0, green: 8'd0, blue: 8'd0, white: 8'd0};

  // Mood colour step per refresh
  localparam logic [LUMA_W-1:0] RED_STEP   = 8'd2;
  localparam logic [LUMA_W-1:0] GREEN_STEP = 8'd3;
  localparam logic [LUMA_W-1:0] BLUE_STEP  = 8'd6;
  localparam logic [LUMA_W-1:0] WHITE_STEP = 8'd1;

  // One result item
  typedef struct packed {
    logic              charge_lamp;
    logic              uv_drive;
    logic              pixel_drive;
    colour_t           colour;
    logic              sleep_request;
    logic [MODE_W-1:0] mode_now;
    logic              battery_low;
  } result_t;

endpackage

### rtl/core/bmt_tick_if.sv
// ----------------------------------------------------------------------------
// bmt_tick_if
// Tick channel: one button edge, charger level and battery sample per transfer.
// ----------------------------------------------------------------------------
interface bmt_tick_if;
  import bmt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 button_edge;
  logic                 charger_present;
  logic [LEVEL_W-1:0]   battery_sample;

  modport source (output valid, output button_edge, output charger_present,
                  output battery_sample, input ready);
  modport sink   (input valid, input button_edge, input charger_present,
                  input battery_sample, output ready);
endinterface

### rtl/core/bmt_light_if.sv
// ----------------------------------------------------------------------------
// bmt_light_if
// Result channel: lamp drives, colour levels, sleep pulse, mode and low flag.
// ----------------------------------------------------------------------------
interface bmt_light_if;
  import bmt_pkg::*;

  logic              valid;
  logic              ready;
  logic              charge_lamp;
  logic              uv_drive;
  logic              pixel_drive;
  logic [LUMA_W-1:0] red_level;
  logic [LUMA_W-1:0] green_level;
  logic [LUMA_W-1:0] blue_level;
  logic [LUMA_W-1:0] white_level;
  logic              sleep_request;
  logic [MODE_W-1:0] mode_now;
  logic              battery_low;

  modport source (output valid, output charge_lamp, output uv_drive, output pixel_drive,
                  output red_level, output green_level, output blue_level,
                  output white_level, output sleep_request, output mode_now,
                  output battery_low, input ready);
  modport sink   (input valid, input charge_lamp, input uv_drive, input pixel_drive,
                  input red_level, input green_level, input blue_level,
                  input white_level, input sleep_request, input mode_now,
                  input battery_low, output ready);
endinterface

### rtl/core/button_mode_timer_controller_core.sv
// ----------------------------------------------------------------------------
// button_mode_timer_controller_core
// Tick driven button, mode, battery and light controller.
// ----------------------------------------------------------------------------
// Each transfer on in_tick is one millisecond tick and produces exactly one
// transfer on out_light. A tick is folded into the controller state in the
// cycle it is taken and its result is registered in the output buffer; the
// block takes one tick per clock indefinitely while out_light keeps up. Results
// go into a two-entry output buffer, so one further tick is still taken while a
// result waits; in_tick.ready drops only when both entries are full. Register
// writes on the cfg_ port take effect from the next tick.
module button_mode_timer_controller_core (
  input  logic                          clk,
  input  logic                          rst_n,
  bmt_tick_if.sink                      in_tick,
  bmt_light_if.source                   out_light,
  input  logic                          cfg_we,
  input  logic [bmt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bmt_pkg::CFG_W-1:0]     cfg_wdata
);
  import bmt_pkg::*;

  // Configuration registers
  logic [LEVEL_W-1:0] low_level_r, full_level_r;
  logic [TICKS_W-1:0] uv_timeout_r, click_guard_r, mode_window_r;
  logic [TICKS_W-1:0] sleep_check_r, refresh_r, sample_r;

  // Controller state
  logic              press_pending_r, press_pending_nxt;
  logic [COUNT_W-1:0] press_count_r, press_count_nxt;
  logic [COUNT_W-1:0] seen_count_r, seen_count_nxt;
  step_t             mode_step_r, mode_step_nxt;
  logic              uv_active_r, uv_active_nxt;
  logic              mood_active_r, mood_active_nxt;
  timer_t            click_el_r, click_el_nxt;
  timer_t            uv_el_r, uv_el_nxt;
  timer_t            refresh_el_r, refresh_el_nxt;
  timer_t            sample_el_r, sample_el_nxt;
  timer_t            sleep_el_r, sleep_el_nxt;
  blink_t            blink_el_r, blink_el_nxt;
  reading_t          reading_r, reading_nxt;
  logic              low_flag_r, low_flag_nxt;
  logic              lamp_charge_r, lamp_charge_nxt;
  logic              lamp_uv_r, lamp_uv_nxt;
  logic              lamp_pixel_r, lamp_pixel_nxt;
  colour_t           mood_r, mood_nxt;
  colour_t           shown_r, shown_nxt;
  logic              sleep_now;
  result_t           result;

  // Output buffer
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    accept, pop;

  assign in_tick.ready = !skid_valid_r;
  assign accept        = in_tick.valid && in_tick.ready;
  assign pop           = out_valid_r && out_light.ready;

  // Saturating tick counter
  function automatic timer_t bump(input timer_t t);
    bump = (t == TIMER_MAX) ? TIMER_MAX : t + timer_t'(1);
  endfunction

  // Elapsed count beyond a period
  function automatic logic past(input timer_t t, input logic [TICKS_W-1:0] period);
    past = TCMP_W'(t) > TCMP_W'(period);
  endfunction

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_level_r   <= RST_LOW_LEVEL;
      full_level_r  <= RST_FULL_LEVEL;
      uv_timeout_r  <= RST_UV_TIMEOUT;
      click_guard_r <= RST_CLICK_GUARD;
      mode_window_r <= RST_MODE_WINDOW;
      sleep_check_r <= RST_SLEEP_CHECK;
      refresh_r     <= RST_REFRESH;
      sample_r      <= RST_SAMPLE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LOW_LEVEL:   low_level_r   <= cfg_wdata[LEVEL_W-1:0];
        REG_FULL_LEVEL:  full_level_r  <= cfg_wdata[LEVEL_W-1:0];
        REG_UV_TIMEOUT:  uv_timeout_r  <= cfg_wdata[TICKS_W-1:0];
        REG_CLICK_GUARD: click_guard_r <= cfg_wdata[TICKS_W-1:0];
        REG_MODE_WINDOW: mode_window_r <= cfg_wdata[TICKS_W-1:0];
        REG_SLEEP_CHECK: sleep_check_r <= cfg_wdata[TICKS_W-1:0];
        REG_REFRESH:     refresh_r     <= cfg_wdata[TICKS_W-1:0];
        REG_SAMPLE:      sample_r      <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the controller by one tick
  always_comb begin
    press_pending_nxt = press_pending_r | in_tick.button_edge;
    press_count_nxt   = press_count_r;
    seen_count_nxt    = seen_count_r;
    mode_step_nxt     = mode_step_r;
    uv_active_nxt     = uv_active_r;
    mood_active_nxt   = mood_active_r;
    blink_el_nxt      = blink_el_r;
    reading_nxt       = reading_r;
    low_flag_nxt      = low_flag_r;
    lamp_charge_nxt   = lamp_charge_r;
    lamp_uv_nxt       = lamp_uv_r;
    lamp_pixel_nxt    = lamp_pixel_r;
    mood_nxt          = mood_r;
    shown_nxt         = shown_r;
    sleep_now         = 1'b0;

    click_el_nxt   = bump(click_el_r);
    refresh_el_nxt = bump(refresh_el_r);
    sample_el_nxt  = bump(sample_el_r);
    sleep_el_nxt   = bump(sleep_el_r);
    uv_el_nxt      = uv_active_r ? bump(uv_el_r) : uv_el_r;

    // Latch the battery reading
    if (past(sample_el_nxt, sample_r)) begin
      reading_nxt   = SAMPLE_BITS'(in_tick.battery_sample);
      sample_el_nxt = '0;
    end

    // Charge lamp, low flag and blink
    if (in_tick.charger_present) begin
      lamp_charge_nxt = !(BCMP_W'(reading_nxt) > BCMP_W'(full_level_r));
      low_flag_nxt    = 1'b0;
      blink_el_nxt    = '0;
    end else if (BCMP_W'(reading_nxt) < BCMP_W'(low_level_r)) begin
      if (blink_el_r == '0) begin
        lamp_charge_nxt = !lamp_charge_r;
      end
      blink_el_nxt = (blink_el_r == BLINK_LAST) ? '0 : blink_el_r + blink_t'(1);
      low_flag_nxt = 1'b1;
    end else begin
      blink_el_nxt = '0;
    end

    // Refresh lamps and colour
    if (past(refresh_el_nxt, refresh_r)) begin
      if (mood_active_r) begin
        lamp_pixel_nxt  = 1'b1;
        mood_nxt.red    = mood_r.red + RED_STEP;
        mood_nxt.green  = mood_r.green + GREEN_STEP;
        mood_nxt.blue   = mood_r.blue + BLUE_STEP;
        mood_nxt.white  = mood_r.white + WHITE_STEP;
        shown_nxt.red   = mood_nxt.red;
        shown_nxt.green = mood_nxt.green;
        shown_nxt.blue  = mood_nxt.blue;
        shown_nxt.white = mood_r.white;
      end else if (uv_active_r) begin
        lamp_pixel_nxt = 1'b1;
        shown_nxt      = UV_COLOUR;
      end else begin
        lamp_pixel_nxt = 1'b0;
        shown_nxt      = DARK;
      end
      lamp_uv_nxt    = uv_active_r;
      refresh_el_nxt = '0;
    end

    // Count a press once the guard time is over
    if (press_pending_nxt && past(click_el_nxt, click_guard_r)) begin
      press_count_nxt   = press_count_r + COUNT_W'(1);
      press_pending_nxt = 1'b0;
      click_el_nxt      = '0;
    end

    // Quiet window: advance the mode after new presses, and stop UV once it has run too long
    if (past(click_el_nxt, mode_window_r)) begin
      if (press_count_nxt != seen_count_r) begin
        mode_step_nxt = mode_step_r + step_t'(1);
      end
      unique case (mode_step_nxt)
        STEP_UV: begin
          if (!uv_active_r) begin
            uv_el_nxt = '0;
          end
          uv_active_nxt   = 1'b1;
          mood_active_nxt = 1'b0;
          if (past(uv_el_nxt, uv_timeout_r)) begin
            mode_step_nxt = STEP_STOP;
          end
        end
        STEP_MOOD: begin
          uv_active_nxt   = 1'b0;
          mood_active_nxt = 1'b1;
        end
        default: begin
          uv_active_nxt   = 1'b0;
          mood_active_nxt = 1'b0;
          mode_step_nxt   = STEP_OFF;
        end
      endcase
      press_pending_nxt = 1'b0;
      seen_count_nxt    = press_count_nxt;
      click_el_nxt      = '0;
    end

    // Sleep decision
    if (past(sleep_el_nxt, sleep_check_r)) begin
      if (low_flag_nxt || (!uv_active_nxt && !mood_active_nxt && !in_tick.charger_present))
      begin
        sleep_now       = 1'b1;
        lamp_charge_nxt = 1'b0;
        lamp_uv_nxt     = 1'b0;
        lamp_pixel_nxt  = 1'b0;
      end
      sleep_el_nxt = '0;
    end

    // Assemble the result
    result.charge_lamp   = lamp_charge_nxt;
    result.uv_drive      = lamp_uv_nxt;
    result.pixel_drive   = lamp_pixel_nxt;
    result.colour        = shown_nxt;
    result.sleep_request = sleep_now;
    result.mode_now      = uv_active_nxt ? MODE_UV : (mood_active_nxt ? MODE_MOOD : MODE_OFF);
    result.battery_low   = low_flag_nxt;
  end

  // Update state on each tick transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_pending_r <= 1'b0;
      press_count_r   <= '0;
      seen_count_r    <= '0;
      mode_step_r     <= STEP_OFF;
      uv_active_r     <= 1'b0;
      mood_active_r   <= 1'b0;
      click_el_r      <= '0;
      uv_el_r         <= '0;
      refresh_el_r    <= '0;
      sample_el_r     <= TIMER_MAX;
      sleep_el_r      <= '0;
      blink_el_r      <= '0;
      reading_r       <= '0;
      low_flag_r      <= 1'b0;
      lamp_charge_r   <= 1'b0;
      lamp_uv_r       <= 1'b0;
      lamp_pixel_r    <= 1'b0;
      mood_r          <= MOOD_RESET;
      shown_r         <= DARK;
    end else if (accept) begin
      press_pending_r <= press_pending_nxt;
      press_count_r   <= press_count_nxt;
      seen_count_r    <= seen_count_nxt;
      mode_step_r     <= mode_step_nxt;
      uv_active_r     <= uv_active_nxt;
      mood_active_r   <= mood_active_nxt;
      click_el_r      <= click_el_nxt;
      uv_el_r         <= uv_el_nxt;
      refresh_el_r    <= refresh_el_nxt;
      sample_el_r     <= sample_el_nxt;
      sleep_el_r      <= sleep_el_nxt;
      blink_el_r      <= blink_el_nxt;
      reading_r       <= reading_nxt;
      low_flag_r      <= low_flag_nxt;
      lamp_charge_r   <= lamp_charge_nxt;
      lamp_uv_r       <= lamp_uv_nxt;
      lamp_pixel_r    <= lamp_pixel_nxt;
      mood_r          <= mood_nxt;
      shown_r         <= shown_nxt;
    end
  end

  // Output buffer control: hold a waiting result, park the next in the skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= result;
      end
    end else if (accept) begin
      skid_r <= result;
    end
  end

  // Drive the result channel
  assign out_light.valid         = out_valid_r;
  assign out_light.charge_lamp   = out_r.charge_lamp;
  assign out_light.uv_drive      = out_r.uv_drive;
  assign out_light.pixel_drive   = out_r.pixel_drive;
  assign out_light.red_level     = out_r.colour.red;
  assign out_light.green_level   = out_r.colour.green;
  assign out_light.blue_level    = out_r.colour.blue;
  assign out_light.white_level   = out_r.colour.white;
  assign out_light.sleep_request = out_r.sleep_request;
  assign out_light.mode_now      = out_r.mode_now;
  assign out_light.battery_low   = out_r.battery_low;

endmodule

### verif/bmt_light_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmt_light_checker
// Watches the tick, light and register ports of the controller, keeps its own
// model of the controller state, predicts one light result per tick transfer
// and compares each light transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module bmt_light_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  bmt_tick_if                  tick,
  bmt_light_if                 light,
  input  logic                 cfg_we,
  input  bmt_pkg::cfg_idx_t    cfg_idx,
  input  logic [bmt_pkg::CFG_W-1:0] cfg_wdata,
  output int                   mismatch_count,
  output int                   pending_results
);
  import bmt_pkg::*;

  // Register copy, indexed by the register map
  logic [CFG_W-1:0] cfg_reg [8];

  // Controller state as seen by the prediction
  logic              press_pending;
  logic [COUNT_W-1:0] press_count;
  logic [COUNT_W-1:0] seen_count;
  step_t             mode_step;
  logic              uv_active;
  logic              mood_active;
  timer_t            click_elapsed;
  timer_t            uv_elapsed;
  timer_t            refresh_elapsed;
  timer_t            sample_elapsed;
  timer_t            sleep_elapsed;
  int                blink_count;
  reading_t          battery_reading;
  logic              low_flag;
  logic              lamp_charge;
  logic              lamp_uv;
  logic              lamp_pixel;
  colour_t           mood_colour;
  colour_t           shown_colour;

  // Light results still owed by the controller, oldest first
  result_t light_due [$];

  function automatic timer_t bump(input timer_t t);
    return (t == TIMER_MAX) ? t : t + timer_t'(1);
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf("charge %0b uv %0b pixel %0b rgbw %0d/%0d/%0d/%0d sleep %0b mode %0d low %0b",
                     r.charge_lamp, r.uv_drive, r.pixel_drive, r.colour.red, r.colour.green,
                     r.colour.blue, r.colour.white, r.sleep_request, r.mode_now,
                     r.battery_low);
  endfunction

  // Fold one tick into the state and return the light result it causes
  function automatic result_t predict_lights(input logic btn, input logic charging,
                                             input reading_t reading);
    result_t r;
    logic    sleep_now;
    sleep_now = 1'b0;
    if (btn) press_pending = 1'b1;

    // Advance the free running timers
    click_elapsed   = bump(click_elapsed);
    refresh_elapsed = bump(refresh_elapsed);
    sample_elapsed  = bump(sample_elapsed);
    sleep_elapsed   = bump(sleep_elapsed);
    if (uv_active) uv_elapsed = bump(uv_elapsed);

    // Latch the battery reading
    if (sample_elapsed > cfg_reg[REG_SAMPLE]) begin
      battery_reading = reading;
      sample_elapsed  = '0;
    end

    // Charge lamp, low flag and low battery blink
    if (charging) begin
      lamp_charge = !(battery_reading > cfg_reg[REG_FULL_LEVEL]);
      low_flag    = 1'b0;
      blink_count = 0;
    end else if (battery_reading < cfg_reg[REG_LOW_LEVEL]) begin
      if (blink_count == 0) lamp_charge = !lamp_charge;
      blink_count++;
      if (blink_count >= BLINK_PERIOD) blink_count = 0;
      low_flag = 1'b1;
    end else begin
      blink_count = 0;
    end

    // Refresh the lamps and the colour sent to the pixel
    if (refresh_elapsed > cfg_reg[REG_REFRESH]) begin
      if (mood_active) begin
        lamp_pixel        = 1'b1;
        mood_colour.red   = mood_colour.red + RED_STEP;
        mood_colour.green = mood_colour.green + GREEN_STEP;
        mood_colour.blue  = mood_colour.blue + BLUE_STEP;
        shown_colour      = mood_colour;
        mood_colour.white = mood_colour.white + WHITE_STEP;
      end else if (uv_active) begin
        lamp_pixel   = 1'b1;
        shown_colour = UV_COLOUR;
      end else begin
        lamp_pixel   = 1'b0;
        shown_colour = DARK;
      end
      lamp_uv         = uv_active;
      refresh_elapsed = '0;
    end

    // Count a pending press once the guard time is over
    if (press_pending && click_elapsed > cfg_reg[REG_CLICK_GUARD]) begin
      press_count   = press_count + COUNT_W'(1);
      press_pending = 1'b0;
      click_elapsed = '0;
    end

    // Quiet window: advance the mode, and force UV off once it has run too long
    if (click_elapsed > cfg_reg[REG_MODE_WINDOW]) begin
      if (press_count != seen_count) mode_step = mode_step + step_t'(1);
      if (mode_step == STEP_UV) begin
        if (!uv_active) uv_elapsed = '0;
        uv_active   = 1'b1;
        mood_active = 1'b0;
        if (uv_elapsed > cfg_reg[REG_UV_TIMEOUT]) mode_step = STEP_STOP;
      end else if (mode_step == STEP_MOOD) begin
        uv_active   = 1'b0;
        mood_active = 1'b1;
      end else begin
        uv_active   = 1'b0;
        mood_active = 1'b0;
        mode_step   = STEP_OFF;
      end
      press_pending = 1'b0;
      seen_count    = press_count;
      click_elapsed = '0;
    end

    // Sleep decision: a sleep request blanks all three lamps
    if (sleep_elapsed > cfg_reg[REG_SLEEP_CHECK]) begin
      if (low_flag || (!uv_active && !mood_active && !charging)) begin
        sleep_now   = 1'b1;
        lamp_charge = 1'b0;
        lamp_uv     = 1'b0;
        lamp_pixel  = 1'b0;
      end
      sleep_elapsed = '0;
    end

    r.charge_lamp   = lamp_charge;
    r.uv_drive      = lamp_uv;
    r.pixel_drive   = lamp_pixel;
    r.colour        = shown_colour;
    r.sleep_request = sleep_now;
    r.mode_now      = uv_active ? MODE_UV : (mood_active ? MODE_MOOD : MODE_OFF);
    r.battery_low   = low_flag;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t due;
    if (!rst_n) begin
      // Hold the model in its reset state
      cfg_reg[REG_LOW_LEVEL]   = CFG_W'(RST_LOW_LEVEL);
      cfg_reg[REG_FULL_LEVEL]  = CFG_W'(RST_FULL_LEVEL);
      cfg_reg[REG_UV_TIMEOUT]  = RST_UV_TIMEOUT;
      cfg_reg[REG_CLICK_GUARD] = RST_CLICK_GUARD;
      cfg_reg[REG_MODE_WINDOW] = RST_MODE_WINDOW;
      cfg_reg[REG_SLEEP_CHECK] = RST_SLEEP_CHECK;
      cfg_reg[REG_REFRESH]     = RST_REFRESH;
      cfg_reg[REG_SAMPLE]      = RST_SAMPLE;
      press_pending   = 1'b0;
      press_count     = '0;
      seen_count      = '0;
      mode_step       = STEP_OFF;
      uv_active       = 1'b0;
      mood_active     = 1'b0;
      click_elapsed   = '0;
      uv_elapsed      = '0;
      refresh_elapsed = '0;
      sample_elapsed  = TIMER_MAX;
      sleep_elapsed   = '0;
      blink_count     = 0;
      battery_reading = '0;
      low_flag        = 1'b0;
      lamp_charge     = 1'b0;
      lamp_uv         = 1'b0;
      lamp_pixel      = 1'b0;
      mood_colour     = MOOD_RESET;
      shown_colour    = DARK;
      light_due.delete();
    end else begin
      // Check a light transfer against the oldest prediction
      if (light.valid && light.ready) begin
        seen.charge_lamp   = light.charge_lamp;
        seen.uv_drive      = light.uv_drive;
        seen.pixel_drive   = light.pixel_drive;
        seen.colour.red    = light.red_level;
        seen.colour.green  = light.green_level;
        seen.colour.blue   = light.blue_level;
        seen.colour.white  = light.white_level;
        seen.sleep_request = light.sleep_request;
        seen.mode_now      = light.mode_now;
        seen.battery_low   = light.battery_low;
        if (light_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: light transfer with no tick behind it: %s", $realtime,
                     describe(seen));
        end else begin
          due = light_due.pop_front();
          if (seen !== due) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: light mismatch", $realtime);
              $display("  expected %s", describe(due));
              $display("  actual   %s", describe(seen));
            end
          end
        end
      end

      // Predict the result of a tick transfer
      if (tick.valid && tick.ready)
        light_due.push_back(predict_lights(tick.button_edge, tick.charger_present,
                                           reading_t'(tick.battery_sample)));

      // Register writes apply from the next tick; the levels keep 12 bits
      if (cfg_we) begin
        if (cfg_idx == REG_LOW_LEVEL || cfg_idx == REG_FULL_LEVEL)
          cfg_reg[cfg_idx] = CFG_W'(cfg_wdata[LEVEL_W-1:0]);
        else
          cfg_reg[cfg_idx] = cfg_wdata;
      end
    end
    pending_results = light_due.size();
  end

endmodule

### verif/tb_button_mode_timer_controller_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_mode_timer_controller_core
// Drives ticks and register settings into the controller, stalls both channels
// at random, and gives the verdict from the checker's mismatch and pending result counts.
// ----------------------------------------------------------------------------
module tb_button_mode_timer_controller_core;
  import bmt_pkg::*;

  typedef enum {REGIME_MIXED, REGIME_LOW} battery_regime_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_idx_t         cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  logic             calm;
  int               cur_low;
  int               cur_full;
  int               mismatch_count;
  int               pending_results;

  reading_t edge_readings [8] = '{12'd0, 12'd4095, 12'd1999, 12'd2000, 12'd2001,
                                  12'd3000, 12'd3001, 12'd2730};

  bmt_tick_if  tick_ch ();
  bmt_light_if light_ch ();

  button_mode_timer_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tick   (tick_ch),
    .out_light (light_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  bmt_light_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .tick            (tick_ch),
    .light           (light_ch),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the light channel at random, except during a calm stretch
  always @(negedge clk) begin
    light_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
  end

  // Hold a tick until it transfers, with an occasional gap in front of it
  task automatic send_tick(input logic btn, input logic chg, input reading_t reading);
    if (!calm && $urandom_range(0, 99) < 16) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    tick_ch.valid           <= 1'b1;
    tick_ch.button_edge     <= btn;
    tick_ch.charger_present <= chg;
    tick_ch.battery_sample  <= reading;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait for every owed light result
  task automatic drain_lights;
    tick_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
  endtask

  task automatic load_settings(input int low, input int full, input int uv, input int guard,
                               input int window, input int sleep, input int refresh,
                               input int sample);
    write_reg(REG_LOW_LEVEL, low);
    write_reg(REG_FULL_LEVEL, full);
    write_reg(REG_UV_TIMEOUT, uv);
    write_reg(REG_CLICK_GUARD, guard);
    write_reg(REG_MODE_WINDOW, window);
    write_reg(REG_SLEEP_CHECK, sleep);
    write_reg(REG_REFRESH, refresh);
    write_reg(REG_SAMPLE, sample);
    cfg_we   <= 1'b0;
    cur_low  = low;
    cur_full = full;
  endtask

  function automatic reading_t near(input int level);
    int v;
    v = level + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return reading_t'(v);
  endfunction

  // Bursts of presses separated by quiet spells, so the mode windows open
  task automatic run_phase(input int count, input battery_regime_t regime);
    logic     burst;
    logic     btn;
    logic     chg;
    reading_t reading;
    int       k;
    burst = 1'b0;
    chg   = (regime == REGIME_MIXED) ? logic'($urandom_range(0, 1)) : 1'b0;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 14) == 0) burst = !burst;
      btn = burst ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 39) == 0);
      if (regime == REGIME_LOW) begin
        reading = reading_t'($urandom_range(0, cur_low - 1));
      end else begin
        if ($urandom_range(0, 24) == 0) chg = !chg;
        case ($urandom_range(0, 3))
          0: reading = near(cur_low);
          1: reading = near(cur_full);
          2: reading = reading_t'($urandom_range(0, 4095));
          default: reading = $urandom_range(0, 1) ? reading_t'(4095) : reading_t'(0);
        endcase
      end
      send_tick(btn, chg, reading);
    end
  endtask

  initial begin
    int i;
    clk                     = 1'b0;
    rst_n                   = 1'b0;
    calm                    = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = REG_LOW_LEVEL;
    cfg_wdata               = '0;
    tick_ch.valid           = 1'b0;
    tick_ch.button_edge     = 1'b0;
    tick_ch.charger_present = 1'b0;
    tick_ch.battery_sample  = '0;
    cur_low                 = RST_LOW_LEVEL;
    cur_full                = RST_FULL_LEVEL;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: the first tick latches the reading
    send_tick(1'b1, 1'b1, 12'd4095);
    send_tick(1'b0, 1'b1, 12'd0);
    send_tick(1'b1, 1'b0, 12'd2730);
    send_tick(1'b0, 1'b0, 12'd1365);
    send_tick(1'b1, 1'b1, 12'd0);
    send_tick(1'b0, 1'b0, 12'd4095);

    // Fast timers: latch every tick, walk the thresholds and the mode steps
    drain_lights();
    load_settings(2000, 3000, 3, 1, 2, 6, 0, 0);
    for (i = 0; i < 18; i++)
      send_tick(i % 5 == 0, i >= 8 && i < 12, edge_readings[i % 8]);

    // Periods at maximum never fire; levels at their extremes
    drain_lights();
    load_settings(0, 4095, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF);
    run_phase(25, REGIME_MIXED);

    // Zero periods fire on every tick
    drain_lights();
    load_settings(4095, 0, 0, 0, 0, 0, 0, 0);
    run_phase(80, REGIME_MIXED);

    // Random short periods, a full drain part way, then a calm stretch
    drain_lights();
    load_settings($urandom_range(1, 4095), $urandom_range(0, 4095), $urandom_range(1, 30),
                  $urandom_range(1, 6), $urandom_range(2, 12), $urandom_range(10, 60),
                  $urandom_range(0, 8), $urandom_range(0, 15));
    run_phase(60, REGIME_MIXED);
    drain_lights();
    calm = 1'b1;
    run_phase(90, REGIME_MIXED);
    calm = 1'b0;

    // Long drained battery spell: the blink toggles again after its period
    drain_lights();
    load_settings($urandom_range(200, 4095), $urandom_range(0, 4095), $urandom_range(1, 40),
                  $urandom_range(1, 6), $urandom_range(2, 12), $urandom_range(20, 80),
                  $urandom_range(0, 10), $urandom_range(0, 20));
    run_phase(540, REGIME_LOW);

    // Longest legal timeout and guard at the other extreme
    drain_lights();
    load_settings($urandom_range(0, 4095), $urandom_range(0, 4095), 65534, 1, 3, 65534,
                  65534, 1);
    run_phase(80, REGIME_MIXED);

    drain_lights();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
